>>> rtl/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared types and constants for the letter digram counter.
// ----------------------------------------------------------------------------
package ldc_pkg;

    localparam int DEF_ALPHABET_SIZE = 26;
    localparam int DEF_COUNT_WIDTH   = 32;

    localparam int BYTE_W   = 8;
    localparam int LETTER_W = 5;
    localparam int OP_W     = 2;
    localparam int OUT_W    = 32;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 64;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_FEED  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] CASE_GAP      = 8'd32;
    localparam logic [BYTE_W-1:0] CODE_OF_A     = 8'd65;
    localparam logic [BYTE_W-1:0] LATIN_LETTERS = 8'd26;
    localparam logic [BYTE_W-1:0] CODE_LOWER_A  = 8'd97;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_start;
        logic sweep_step;
        logic issue_read;
        logic commit;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic in_clear;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/letter_digram_counter.sv
// ----------------------------------------------------------------------------
// letter_digram_counter
// Counts adjacent letter pairs in a byte stream into a saturating pair table.
//
//   channel | dir | tdata (low bit up)                          | tuser
//   s_      | in  | data_byte, first_letter, second_letter, pad | op
//   m_      | out | pair_count, letter_count                    | -
//
// Feed, read and unused-op words pass through accept, table read and read-modify-write
// into the result register.
// Clear is accepted and then zeroes the table, one zero write a cycle, the last
// write waiting on a free result register. After reset the same sweep runs
// with s_tready low. A result waiting on m_tready holds only the commit step,
// or the last sweep step of a clear; the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module letter_digram_counter
    import ldc_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // data_byte, first_letter, second_letter
    input  logic [OP_W-1:0]     s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // pair_count, letter_count
);

    cmd_t cmd;
    sts_t sts;

    ldc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ldc_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/ldc_ctrl.sv
// ----------------------------------------------------------------------------
// ldc_ctrl
// Sequencer: table clear sweep, item accept, memory read, read-modify-write.
// ----------------------------------------------------------------------------
module ldc_ctrl
    import ldc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        reply_next = reply_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sts.sweep_last) begin
                    if (!reply_reg) begin
                        cmd.sweep_step = 1'b1;
                        state_next     = ST_IDLE;
                    end else if (sts.out_free) begin
                        cmd.sweep_step = 1'b1;
                        cmd.out_zero   = 1'b1;
                        reply_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.sweep_step = 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (sts.in_clear) begin
                        cmd.sweep_start = 1'b1;
                        reply_next      = 1'b1;
                        state_next      = ST_SWEEP;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.issue_read = 1'b1;
                state_next     = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

endmodule

>>> rtl/ldc_datapath.sv
// ----------------------------------------------------------------------------
// ldc_datapath
// Pair table memory, letter decode, saturating counters and result register.
// ----------------------------------------------------------------------------
module ldc_datapath
    import ldc_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CELLS = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0]       LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]       ALPHA_A   = AW'(ALPHABET_SIZE);
    localparam logic [LETTER_W:0]   ALPHA_L   = (LETTER_W+1)'(ALPHABET_SIZE);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] mem [CELLS];

    logic [OP_W-1:0]        op_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic [LETTER_W-1:0]    row_reg;
    logic [LETTER_W-1:0]    col_reg;
    logic [LETTER_W-1:0]    prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0] letters_reg, letters_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic [COUNT_WIDTH-1:0] rd_reg;
    logic                   valid_reg, valid_next;
    logic [OUT_W-1:0]       pair_out_reg, pair_out_next;
    logic [OUT_W-1:0]       lett_out_reg, lett_out_next;

    logic [BYTE_W-1:0]      upper;
    logic [BYTE_W-1:0]      offset;
    logic [LETTER_W-1:0]    idx;
    logic                   letter_ok;
    logic                   have_pair;
    logic                   read_ok;
    logic [AW-1:0]          addr;
    logic [COUNT_WIDTH-1:0] pair_inc;
    logic [COUNT_WIDTH-1:0] letters_inc;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;

    // letter decode of the held byte
    always_comb begin
        if (byte_reg >= CODE_LOWER_A && byte_reg < CODE_LOWER_A + LATIN_LETTERS) begin
            upper = byte_reg - CASE_GAP;
        end else begin
            upper = byte_reg;
        end
        offset    = upper - CODE_OF_A;
        idx       = offset[LETTER_W-1:0];
        letter_ok = (op_reg == OP_FEED) && (upper >= CODE_OF_A)
                    && (offset < LATIN_LETTERS) && ({1'b0, idx} < ALPHA_L);
        have_pair = letter_ok && (letters_reg != '0) && ({1'b0, prev_reg} < ALPHA_L);
        read_ok   = (op_reg == OP_READ) && ({1'b0, row_reg} < ALPHA_L)
                    && ({1'b0, col_reg} < ALPHA_L);
        if (op_reg == OP_FEED) begin
            addr = AW'(prev_reg) * ALPHA_A + AW'(idx);
        end else begin
            addr = AW'(row_reg) * ALPHA_A + AW'(col_reg);
        end
        pair_inc    = (rd_reg == CNT_MAX) ? rd_reg : rd_reg + 1'b1;
        letters_inc = (letters_reg == CNT_MAX) ? letters_reg : letters_reg + 1'b1;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = addr;
        mem_wd = pair_inc;
        if (cmd.sweep_step) begin
            mem_we = 1'b1;
            mem_wa = sweep_reg;
            mem_wd = '0;
        end else if (cmd.commit && have_pair) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.issue_read) begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata[BYTE_W-1:0];
            row_reg  <= s_tdata[BYTE_W +: LETTER_W];
            col_reg  <= s_tdata[BYTE_W+LETTER_W +: LETTER_W];
        end
        pair_out_reg <= pair_out_next;
        lett_out_reg <= lett_out_next;
    end

    always_comb begin
        prev_next     = prev_reg;
        letters_next  = letters_reg;
        sweep_next    = sweep_reg;
        valid_next    = valid_reg && !m_tready;
        pair_out_next = pair_out_reg;
        lett_out_next = lett_out_reg;
        if (cmd.load && cmd.sweep_start) begin
            prev_next    = '0;
            letters_next = '0;
            sweep_next   = '0;
        end
        if (cmd.sweep_step) begin
            sweep_next = sweep_reg + 1'b1;
        end
        if (cmd.out_zero) begin
            valid_next    = 1'b1;
            pair_out_next = '0;
            lett_out_next = '0;
        end
        if (cmd.commit) begin
            valid_next = 1'b1;
            if (letter_ok) begin
                prev_next    = idx;
                letters_next = letters_inc;
            end
            lett_out_next = OUT_W'(letter_ok ? letters_inc : letters_reg);
            if (have_pair) begin
                pair_out_next = OUT_W'(pair_inc);
            end else if (read_ok) begin
                pair_out_next = OUT_W'(rd_reg);
            end else begin
                pair_out_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            letters_reg <= '0;
            sweep_reg   <= '0;
            valid_reg   <= 1'b0;
        end else begin
            prev_reg    <= prev_next;
            letters_reg <= letters_next;
            sweep_reg   <= sweep_next;
            valid_reg   <= valid_next;
        end
    end

    assign sts.in_clear   = (s_tuser == OP_CLEAR);
    assign sts.sweep_last = (sweep_reg == LAST_CELL);
    assign sts.out_free   = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {lett_out_reg, pair_out_reg};

endmodule

>>> rtl/ldc_checker.sv
// ----------------------------------------------------------------------------
// ldc_checker
// Port-level checks for the letter digram counter.
// ----------------------------------------------------------------------------
module ldc_checker
    import ldc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // table sweep after reset blocks input
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during reset sweep");

    // one word in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

endmodule

bind letter_digram_counter ldc_checker u_ldc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
